// ===== rtl/core/cigar_read_to_reference_bases_defines.svh =====
// Assertion macros shared by the cigar read-to-reference block.
// No dependencies; included by crtrb_back, which checks its own logic.
`ifndef CIGAR_READ_TO_REFERENCE_BASES_DEFINES_SVH
`define CIGAR_READ_TO_REFERENCE_BASES_DEFINES_SVH

// Check a condition at every edge outside reset.
`define CRTRB_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("crtrb check failed");

// Check that an antecedent implies a consequent in the same cycle.
`define CRTRB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crtrb check failed");

`endif

// ===== rtl/core/crtrb_pkg.sv =====
// Shared types, codes and tables of the cigar read-to-reference block.
// No dependencies.
package crtrb_pkg;

    localparam logic [2:0] MODE_BEGIN = 3'd0;
    localparam logic [2:0] MODE_BASE  = 3'd1;
    localparam logic [2:0] MODE_CIGAR = 3'd2;
    localparam logic [2:0] MODE_END   = 3'd3;
    localparam logic [2:0] MODE_ADD   = 3'd4;
    localparam logic [2:0] MODE_CLEAR = 3'd5;

    localparam logic [3:0] CIG_M = 4'd0;
    localparam logic [3:0] CIG_I = 4'd1;
    localparam logic [3:0] CIG_D = 4'd2;
    localparam logic [3:0] CIG_N = 4'd3;
    localparam logic [3:0] CIG_S = 4'd4;
    localparam logic [3:0] CIG_H = 4'd5;
    localparam logic [3:0] CIG_EQ = 4'd7;
    localparam logic [3:0] CIG_X = 4'd8;
    localparam logic [3:0] CIG_B = 4'd9;

    // Operation classes handed from front to back
    localparam logic [2:0] OPC_NONE  = 3'd0;
    localparam logic [2:0] OPC_MATCH = 3'd1;
    localparam logic [2:0] OPC_INS   = 3'd2;
    localparam logic [2:0] OPC_DEL   = 3'd3;
    localparam logic [2:0] OPC_SKIP  = 3'd4;
    localparam logic [2:0] OPC_STOP  = 3'd5;

    localparam logic [7:0] DEL_QUAL = 8'd10;
    localparam logic [7:0] CHAR_GAP = 8'h2D;
    localparam logic [7:0] CHAR_UNK = 8'h3F;

    typedef struct packed {
        logic [2:0]  mode;
        logic [30:0] position;
        logic [15:0] flag;
        logic [3:0]  base;
        logic [7:0]  qual;
        logic [2:0]  opc;
        logic [6:0]  len;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [30:0] ref_position;
        logic [7:0]  base_char;
        logic [7:0]  base_quality;
        logic [15:0] match_span;
        logic [15:0] flag_out;
        logic        last;
    } t_result;

    function automatic logic [7:0] code_char(input logic [3:0] code);
        logic [7:0] ch;
        case (code)
            4'd1:    ch = 8'h41;
            4'd2:    ch = 8'h43;
            4'd4:    ch = 8'h47;
            4'd8:    ch = 8'h54;
            4'd14:   ch = CHAR_GAP;
            4'd15:   ch = 8'h4E;
            default: ch = CHAR_UNK;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] op_class(input logic [3:0] op);
        logic [2:0] c;
        case (op)
            CIG_M, CIG_EQ, CIG_X: c = OPC_MATCH;
            CIG_I:                c = OPC_INS;
            CIG_D:                c = OPC_DEL;
            CIG_N:                c = OPC_SKIP;
            CIG_S, CIG_H, CIG_B:  c = OPC_STOP;
            default:              c = OPC_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/crtrb_ifs.sv =====
// Channel interfaces of the cigar read-to-reference block: input items,
// result items and the configuration write. No dependencies.
interface crtrb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [30:0] position;
    logic [15:0] read_flag;
    logic [3:0]  base_code;
    logic [7:0]  quality;
    logic [3:0]  cigar_op;
    logic [6:0]  op_length;
    modport source(output valid, mode, position, read_flag, base_code, quality, cigar_op,
                   op_length, input ready);
    modport sink(input valid, mode, position, read_flag, base_code, quality, cigar_op,
                 op_length, output ready);
endinterface

interface crtrb_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [30:0] ref_position;
    logic [7:0]  base_char;
    logic [7:0]  base_quality;
    logic [15:0] match_span;
    logic [15:0] flag_out;
    logic        last;
    modport source(output valid, kind, ref_position, base_char, base_quality, match_span,
                   flag_out, last, input ready);
    modport sink(input valid, kind, ref_position, base_char, base_quality, match_span,
                 flag_out, last, output ready);
endinterface

interface crtrb_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// ===== rtl/core/cigar_read_to_reference_bases.sv =====
// Top level of the cigar read-to-reference block: front end, back end and
// the use-all configuration register. Depends on crtrb_pkg, crtrb_ifs, front, back.
//
// i_in carries items: begin read, query base, cigar op piece, end read, add
// filter position, clear filter. o_out carries placed bases and the end-of-read
// summary; last marks the final result of an item. i_cfg writes
// use_all_positions (reset 1); write it only while nothing is in flight.
// Items pass a two-entry command queue in the front end; the back end runs one
// command at a time. Begin, base, insert, skip, stop, filter add and clear are
// done in the idle state. A match or deletion piece is accepted, then each
// position steps through S_POS, S_RD for a queued base (skipped for a gap or an
// empty queue), S_FILT and S_PLACE; the piece closes through S_POS and S_FLUSH.
// With the filter on, each position compares the filter entries one at a time,
// and a miss drops the place step. The summary is built in S_SUM and registered.
// Synchronous active-low reset empties the command queue, cursor, base queue
// pointers and filter count; RAM contents are left as they are. A stalled
// receiver holds the output register and one more result waits in the back end;
// the back end then stalls and the command queue fills, dropping i_in.ready.
module cigar_read_to_reference_bases import crtrb_pkg::*; #(
    parameter int READ_DEPTH   = 256,
    parameter int MAX_RUN      = 64,
    parameter int FILTER_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    crtrb_in_if.sink      i_in,
    crtrb_out_if.source   o_out,
    crtrb_cfg_if.sink     i_cfg
);
    logic r_use_all;
    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    // Configuration writes land at once
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_all <= 1'b1;
        end else if (i_cfg.valid) begin
            r_use_all <= i_cfg.data;
        end
    end

    crtrb_front #(.MAX_RUN(MAX_RUN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    crtrb_back #(.READ_DEPTH(READ_DEPTH), .FILTER_DEPTH(FILTER_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_use_all   (r_use_all),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_out       (o_out)
    );
endmodule

// ===== rtl/core/crtrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crtrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/crtrb_front.sv =====
// Front end: accept input items, classify cigar ops, clamp lengths, and
// queue decoded commands. Depends on crtrb_pkg and crtrb_in_if.
module crtrb_front import crtrb_pkg::*; #(
    parameter int MAX_RUN = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crtrb_in_if.sink     i_in,
    output logic         o_cmd_valid,
    output t_cmd         o_cmd,
    input  logic         i_cmd_ready
);
    localparam logic [6:0] RUN_CAP = 7'(MAX_RUN);

    t_cmd       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_count, n_count;
    t_cmd       in_cmd;
    logic       push, pop;

    always_comb begin
        in_cmd.mode     = i_in.mode;
        in_cmd.position = i_in.position;
        in_cmd.flag     = i_in.read_flag;
        in_cmd.base     = i_in.base_code;
        in_cmd.qual     = i_in.quality;
        in_cmd.opc      = op_class(i_in.cigar_op);
        in_cmd.len      = (i_in.op_length > RUN_CAP) ? RUN_CAP : i_in.op_length;
    end

    assign i_in.ready  = (r_count != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_mem[r_rp];

    always_comb begin
        n_wp    = push ? ~r_wp : r_wp;
        n_rp    = pop ? ~r_rp : r_rp;
        n_count = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_cmd;
        end
    end
endmodule

// ===== rtl/core/crtrb_back.sv =====
// Back end: execute queued commands, own the base queue and filter RAMs,
// and drive the result channel. Depends on crtrb_pkg, crtrb_ram, crtrb_out_if.
`include "cigar_read_to_reference_bases_defines.svh"
module crtrb_back import crtrb_pkg::*; #(
    parameter int READ_DEPTH   = 256,
    parameter int FILTER_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_use_all,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_ready,
    crtrb_out_if.source   o_out
);
    localparam int AW  = $clog2(READ_DEPTH);
    localparam int FAW = FILTER_DEPTH > 1 ? $clog2(FILTER_DEPTH) : 1;
    localparam int CW  = (AW + 1 > 7) ? AW + 1 : 7;
    localparam logic [AW:0]  QFULL = (AW + 1)'(READ_DEPTH);
    localparam logic [FAW:0] FCAP  = (FAW + 1)'(FILTER_DEPTH);
    localparam logic [AW:0]    PTR_ONE  = (AW + 1)'(1);
    localparam logic [FAW:0]   FCNT_ONE = (FAW + 1)'(1);
    localparam logic [FAW-1:0] FIDX_ONE = FAW'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POS   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_FILT  = 3'd3;
    localparam logic [2:0] S_FCMP  = 3'd4;
    localparam logic [2:0] S_PLACE = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;
    localparam logic [2:0] S_SUM   = 3'd7;

    logic [2:0]   r_state, n_state;
    logic [31:0]  r_cursor, n_cursor;
    logic [AW:0]  r_rptr, n_rptr, r_wptr, n_wptr;
    logic         r_stop, n_stop;
    logic [15:0]  r_run, n_run, r_best, n_best, r_flag, n_flag;
    logic [FAW:0] r_fcnt, n_fcnt;
    logic [FAW-1:0] r_fidx, n_fidx;
    logic [6:0]   r_cnt, n_cnt, r_len, n_len;
    logic         r_del, n_del;
    logic [7:0]   r_cand_ch, n_cand_ch, r_cand_q, n_cand_q;
    t_result      r_pend, n_pend, r_out, n_out;
    logic         r_pend_v, n_pend_v, r_out_v, n_out_v;

    logic [AW:0]    queued;
    logic [CW-1:0]  ins_len;
    logic [16:0]    run_sum;
    logic           out_free, hit, miss;
    logic           in_op;
    t_result        cand;

    logic           bq_we;
    logic [AW-1:0]  bq_waddr, bq_raddr;
    logic [11:0]    bq_wdata, bq_rdata;
    logic           f_we;
    logic [FAW-1:0] f_waddr, f_raddr;
    logic [30:0]    f_wdata, f_rdata;

    crtrb_ram #(.WIDTH(12), .DEPTH(READ_DEPTH)) u_base_ram (
        .i_clk(i_clk), .i_we(bq_we), .i_waddr(bq_waddr), .i_wdata(bq_wdata),
        .i_raddr(bq_raddr), .o_rdata(bq_rdata)
    );

    crtrb_ram #(.WIDTH(31), .DEPTH(FILTER_DEPTH)) u_filter_ram (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    assign queued      = r_wptr - r_rptr;
    assign out_free    = !r_out_v || o_out.ready;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign ins_len     = (CW'(i_cmd.len) > CW'(queued)) ? CW'(queued) : CW'(i_cmd.len);
    assign run_sum     = {1'b0, r_run} + {10'd0, r_len};
    assign hit         = !r_cursor[31] && (f_rdata == r_cursor[30:0]);
    assign in_op       = (r_state != S_IDLE) && (r_state != S_SUM);

    always_comb begin
        cand.kind         = 1'b0;
        cand.ref_position = r_cursor[30:0];
        cand.base_char    = r_cand_ch;
        cand.base_quality = r_cand_q;
        cand.match_span   = 16'd0;
        cand.flag_out     = 16'd0;
        cand.last         = 1'b0;
    end

    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_rptr    = r_rptr;
        n_wptr    = r_wptr;
        n_stop    = r_stop;
        n_run     = r_run;
        n_best    = r_best;
        n_flag    = r_flag;
        n_fcnt    = r_fcnt;
        n_fidx    = r_fidx;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_del     = r_del;
        n_cand_ch = r_cand_ch;
        n_cand_q  = r_cand_q;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_out     = r_out;
        n_out_v   = (r_out_v && o_out.ready) ? 1'b0 : r_out_v;
        bq_we     = 1'b0;
        bq_waddr  = r_wptr[AW-1:0];
        bq_wdata  = {i_cmd.base, i_cmd.qual};
        bq_raddr  = r_rptr[AW-1:0];
        f_we      = 1'b0;
        f_waddr   = r_fcnt[FAW-1:0];
        f_wdata   = i_cmd.position;
        f_raddr   = r_fidx;
        miss      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.mode)
                        MODE_BEGIN: begin
                            n_cursor = {1'b0, i_cmd.position} + 32'd1;
                            n_rptr   = '0;
                            n_wptr   = '0;
                            n_stop   = 1'b0;
                            n_run    = 16'd0;
                            n_best   = 16'd0;
                            n_flag   = i_cmd.flag;
                        end
                        MODE_BASE: begin
                            if (queued != QFULL) begin
                                bq_we  = 1'b1;
                                n_wptr = r_wptr + PTR_ONE;
                            end
                        end
                        MODE_CIGAR: begin
                            if (!r_stop) begin
                                case (i_cmd.opc)
                                    OPC_MATCH, OPC_DEL: begin
                                        n_cnt   = i_cmd.len;
                                        n_len   = i_cmd.len;
                                        n_del   = (i_cmd.opc == OPC_DEL);
                                        n_state = S_POS;
                                    end
                                    OPC_INS: begin
                                        n_rptr = r_rptr + ins_len[AW:0];
                                        n_run  = 16'd0;
                                    end
                                    OPC_SKIP: begin
                                        n_cursor = r_cursor + {25'd0, i_cmd.len};
                                        n_stop   = 1'b1;
                                        n_run    = 16'd0;
                                    end
                                    OPC_STOP: begin
                                        n_stop = 1'b1;
                                        n_run  = 16'd0;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        MODE_END: n_state = S_SUM;
                        MODE_ADD: begin
                            if (r_fcnt != FCAP) begin
                                f_we   = 1'b1;
                                n_fcnt = r_fcnt + FCNT_ONE;
                            end
                        end
                        MODE_CLEAR: n_fcnt = '0;
                        default: ;
                    endcase
                end
            end
            S_POS: begin
                if (r_cnt == 7'd0) begin
                    // Close the op: update match span bookkeeping
                    if (!r_del) begin
                        n_run  = run_sum[16] ? 16'hFFFF : run_sum[15:0];
                        n_best = (n_run > r_best) ? n_run : r_best;
                    end else begin
                        n_run = 16'd0;
                    end
                    n_state = S_FLUSH;
                end else if (r_del) begin
                    n_cand_ch = CHAR_GAP;
                    n_cand_q  = DEL_QUAL;
                    n_state   = S_FILT;
                end else if (queued != '0) begin
                    n_rptr  = r_rptr + PTR_ONE;
                    n_state = S_RD;
                end else begin
                    n_cand_ch = CHAR_UNK;
                    n_cand_q  = 8'd0;
                    n_state   = S_FILT;
                end
            end
            S_RD: begin
                n_cand_ch = code_char(bq_rdata[11:8]);
                n_cand_q  = bq_rdata[7:0];
                n_state   = S_FILT;
            end
            S_FILT: begin
                if (i_use_all) begin
                    n_state = S_PLACE;
                end else if (r_fcnt == '0) begin
                    miss = 1'b1;
                end else begin
                    f_raddr = '0;
                    n_fidx  = '0;
                    n_state = S_FCMP;
                end
            end
            S_FCMP: begin
                if (hit) begin
                    n_state = S_PLACE;
                end else if (({1'b0, r_fidx} + FCNT_ONE) == r_fcnt) begin
                    miss = 1'b1;
                end else begin
                    f_raddr = r_fidx + FIDX_ONE;
                    n_fidx  = r_fidx + FIDX_ONE;
                end
            end
            S_PLACE: begin
                // Hold one result back so the last of an op can be marked
                if (!r_pend_v) begin
                    n_pend   = cand;
                    n_pend_v = 1'b1;
                    n_cursor = r_cursor + 32'd1;
                    n_cnt    = r_cnt - 7'd1;
                    n_state  = S_POS;
                end else if (out_free) begin
                    n_out    = r_pend;
                    n_out_v  = 1'b1;
                    n_pend   = cand;
                    n_cursor = r_cursor + 32'd1;
                    n_cnt    = r_cnt - 7'd1;
                    n_state  = S_POS;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    n_out.kind         = 1'b1;
                    n_out.ref_position = r_cursor[30:0];
                    n_out.base_char    = 8'd0;
                    n_out.base_quality = 8'd0;
                    n_out.match_span   = r_best;
                    n_out.flag_out     = r_flag;
                    n_out.last         = 1'b1;
                    n_out_v            = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (miss) begin
            // Drop the filtered position and advance
            n_cursor = r_cursor + 32'd1;
            n_cnt    = r_cnt - 7'd1;
            n_state  = S_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= 32'd0;
            r_rptr   <= '0;
            r_wptr   <= '0;
            r_stop   <= 1'b0;
            r_run    <= 16'd0;
            r_best   <= 16'd0;
            r_flag   <= 16'd0;
            r_fcnt   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_rptr   <= n_rptr;
            r_wptr   <= n_wptr;
            r_stop   <= n_stop;
            r_run    <= n_run;
            r_best   <= n_best;
            r_flag   <= n_flag;
            r_fcnt   <= n_fcnt;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fidx    <= n_fidx;
        r_cnt     <= n_cnt;
        r_len     <= n_len;
        r_del     <= n_del;
        r_cand_ch <= n_cand_ch;
        r_cand_q  <= n_cand_q;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    assign o_out.valid        = r_out_v;
    assign o_out.kind         = r_out.kind;
    assign o_out.ref_position = r_out.ref_position;
    assign o_out.base_char    = r_out.base_char;
    assign o_out.base_quality = r_out.base_quality;
    assign o_out.match_span   = r_out.match_span;
    assign o_out.flag_out     = r_out.flag_out;
    assign o_out.last         = r_out.last;

    `CRTRB_ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, queued <= QFULL)
    `CRTRB_ASSERT_ALWAYS(a_filter_bound, i_clk, i_rst_n, r_fcnt <= FCAP)
    `CRTRB_ASSERT_IMPLIES(a_pend_in_op, i_clk, i_rst_n, r_pend_v, in_op)
endmodule

// ===== sim/tb.sv =====
// Testbench of cigar_read_to_reference_bases: drives begin, base, cigar, end and
// filter items, predicts the placed bases and summaries, and compares them.
// Depends on crtrb_pkg, crtrb_ifs and the RTL of the block.
module tb;
    import crtrb_pkg::*;

    localparam int QDEPTH   = 256;
    localparam int RUN_CAP  = 64;
    localparam int FDEPTH   = 64;
    localparam int SETTLE   = 2 * RUN_CAP * (FDEPTH + 4) + 16;
    localparam int WDOG_MAX = 100000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    crtrb_in_if  in_ch();
    crtrb_out_if out_ch();
    crtrb_cfg_if cfg_ch();

    cigar_read_to_reference_bases DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .o_out(out_ch.source), .i_cfg(cfg_ch.sink)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state, a copy of the block's walk state
    logic        use_all;
    logic [31:0] cursor;
    logic [11:0] bases[QDEPTH];
    int          rd_ptr, wr_ptr;
    logic        stopped;
    int          run_len, best_run;
    logic [15:0] flag_held;
    logic [30:0] filt_pos[FDEPTH];
    logic        filt_ok[FDEPTH];

    t_result placed_q[$];
    int      errors = 0;
    int      n_items = 0, n_results = 0;
    int      idle_cycles = 0;
    int      hold_cnt = 0;
    logic    stall_en = 1'b1;

    function automatic logic [7:0] letter(input logic [3:0] c);
        case (c)
            4'd1: return "A";
            4'd2: return "C";
            4'd4: return "G";
            4'd8: return "T";
            4'd14: return "-";
            4'd15: return "N";
            default: return "?";
        endcase
    endfunction

    function automatic logic passes_filter(input logic [31:0] p);
        if (use_all) return 1'b1;
        for (int i = 0; i < FDEPTH; i++)
            if (filt_ok[i] && {1'b0, filt_pos[i]} == p) return 1'b1;
        return 1'b0;
    endfunction

    // Emit one placed base if it passes the filter and the run cap allows
    task automatic put_base(inout int cnt, input logic [7:0] ch, input logic [7:0] q);
        t_result r;
        if (passes_filter(cursor) && cnt < RUN_CAP) begin
            r = '0;
            r.ref_position = cursor[30:0];
            r.base_char = ch;
            r.base_quality = q;
            placed_q.insert(placed_q.size(), r);
            cnt++;
        end
    endtask

    task automatic predict_item(input logic [2:0] md, input logic [30:0] pos,
                                input logic [15:0] flg, input logic [3:0] bc,
                                input logic [7:0] ql, input logic [3:0] op,
                                input logic [6:0] ln);
        int len, cnt, avail;
        t_result r;
        logic [11:0] e;
        len = (ln > RUN_CAP) ? RUN_CAP : ln;
        cnt = 0;
        case (md)
            MODE_BEGIN: begin
                cursor = {1'b0, pos} + 32'd1;
                rd_ptr = 0; wr_ptr = 0; stopped = 0;
                run_len = 0; best_run = 0; flag_held = flg;
            end
            MODE_BASE: begin
                if (wr_ptr - rd_ptr < QDEPTH) begin
                    bases[wr_ptr % QDEPTH] = {bc, ql};
                    wr_ptr++;
                end
            end
            MODE_CIGAR: if (!stopped) begin
                case (op)
                    CIG_M, CIG_EQ, CIG_X: begin
                        for (int j = 0; j < len; j++) begin
                            if (wr_ptr > rd_ptr) begin
                                e = bases[rd_ptr % QDEPTH];
                                rd_ptr++;
                                put_base(cnt, letter(e[11:8]), e[7:0]);
                            end else begin
                                put_base(cnt, CHAR_UNK, 8'd0);
                            end
                            cursor++;
                        end
                        run_len += len;
                        if (run_len > 65535) run_len = 65535;
                        if (run_len > best_run) best_run = run_len;
                    end
                    CIG_I: begin
                        avail = wr_ptr - rd_ptr;
                        rd_ptr += (len > avail) ? avail : len;
                        run_len = 0;
                    end
                    CIG_D: begin
                        for (int j = 0; j < len; j++) begin
                            put_base(cnt, CHAR_GAP, DEL_QUAL);
                            cursor++;
                        end
                        run_len = 0;
                    end
                    CIG_N: begin
                        cursor += len; stopped = 1; run_len = 0;
                    end
                    CIG_S, CIG_H, CIG_B: begin
                        stopped = 1; run_len = 0;
                    end
                    default: ;
                endcase
                if (cnt > 0) placed_q[$].last = 1'b1;
            end
            MODE_END: begin
                r = '0;
                r.kind = 1'b1;
                r.ref_position = cursor[30:0];
                r.match_span = best_run[15:0];
                r.flag_out = flag_held;
                r.last = 1'b1;
                placed_q.insert(placed_q.size(), r);
            end
            MODE_ADD: begin
                for (int i = 0; i < FDEPTH; i++)
                    if (!filt_ok[i]) begin
                        filt_pos[i] = pos; filt_ok[i] = 1; break;
                    end
            end
            MODE_CLEAR: for (int i = 0; i < FDEPTH; i++) filt_ok[i] = 0;
            default: ;
        endcase
    endtask

    // Random gap: mostly none or short, a few long; drop valid while waiting
    task automatic gap();
        int n, k;
        k = $urandom_range(0, 99);
        if (k < 55) n = 0;
        else if (k < 95) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 30);
        if (n > 0) in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Send one item and predict what it causes
    task automatic send_item(input logic [2:0] md, input logic [30:0] pos = 0,
                             input logic [15:0] flg = 0, input logic [3:0] bc = 0,
                             input logic [7:0] ql = 0, input logic [3:0] op = 0,
                             input logic [6:0] ln = 0);
        gap();
        in_ch.valid <= 1'b1;
        in_ch.mode <= md; in_ch.position <= pos; in_ch.read_flag <= flg;
        in_ch.base_code <= bc; in_ch.quality <= ql;
        in_ch.cigar_op <= op; in_ch.op_length <= ln;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(md, pos, flg, bc, ql, op, ln);
        n_items++;
    endtask

    // Hold until every expected result is out and the block has settled
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (placed_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_use_all(input logic v);
        drain();
        cfg_ch.valid <= 1'b1; cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        use_all = v;
    endtask

    // Check each result against the oldest expected one
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (placed_q.size() == 0) begin
                $error("unexpected result at position %0d", out_ch.ref_position);
                errors++;
            end else begin
                exp_r = placed_q.pop_front();
                if (out_ch.kind !== exp_r.kind) begin
                    $error("kind exp %0d got %0d", exp_r.kind, out_ch.kind); errors++;
                end
                if (out_ch.ref_position !== exp_r.ref_position) begin
                    $error("ref_position exp %0d got %0d", exp_r.ref_position,
                           out_ch.ref_position); errors++;
                end
                if (out_ch.base_char !== exp_r.base_char) begin
                    $error("base_char exp %h got %h", exp_r.base_char, out_ch.base_char);
                    errors++;
                end
                if (out_ch.base_quality !== exp_r.base_quality) begin
                    $error("base_quality exp %0d got %0d", exp_r.base_quality,
                           out_ch.base_quality); errors++;
                end
                if (out_ch.match_span !== exp_r.match_span) begin
                    $error("match_span exp %0d got %0d", exp_r.match_span,
                           out_ch.match_span); errors++;
                end
                if (out_ch.flag_out !== exp_r.flag_out) begin
                    $error("flag_out exp %h got %h", exp_r.flag_out, out_ch.flag_out);
                    errors++;
                end
                if (out_ch.last !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, out_ch.last); errors++;
                end
            end
        end
    end

    // Receiver stalls: mostly ready, often short stalls, a few long ones
    always @(posedge i_clk) begin
        int k;
        k = $urandom_range(0, 99);
        if (!stall_en) begin
            hold_cnt = 0;
            out_ch.ready <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            out_ch.ready <= 1'b0;
        end else if (k < 70) begin
            out_ch.ready <= 1'b1;
        end else if (k < 97) begin
            out_ch.ready <= 1'b0;
        end else begin
            hold_cnt = $urandom_range(8, 40);
            out_ch.ready <= 1'b0;
        end
    end

    // Watchdog: count cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        send_item(MODE_BEGIN, 31'h7FFF_FFFE, 16'hFFFF);
        for (int c = 0; c < 16; c++)
            send_item(MODE_BASE, 0, 0, c[3:0], (c[0]) ? 8'hFF : 8'h00);
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_M, 7'd5);     // crosses the 2^31 line
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_I, 7'd2);
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_EQ, 7'd4);
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_D, 7'd3);
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_X, 7'd127);   // too long, and underflow
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_I, 7'd64);    // more than queued
        send_item(MODE_CIGAR, 0, 0, 0, 0, 4'd6, 7'd3);      // padding ignored
        send_item(MODE_CIGAR, 0, 0, 0, 0, 4'd12, 7'd3);     // unused op ignored
        send_item(3'd6); send_item(3'd7);
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_N, 7'd100);
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_M, 7'd3);     // stopped, ignored
        send_item(MODE_END);
    endtask

    task automatic test_stop_ops();
        logic [3:0] stops[3];
        stops = '{CIG_S, CIG_H, CIG_B};
        for (int i = 0; i < 3; i++) begin
            send_item(MODE_BEGIN, 0, 16'h5A5A);
            send_item(MODE_CIGAR, 0, 0, 0, 0, stops[i], 7'd1);
            send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_D, 7'd2);
            send_item(MODE_END);
        end
    endtask

    task automatic test_queue_full();
        send_item(MODE_BEGIN, 31'd1000, 16'h0001);
        for (int i = 0; i < QDEPTH + 2; i++)
            send_item(MODE_BASE, 0, 0, 4'd1 << (i % 4), i[7:0]);
        for (int i = 0; i < 5; i++) send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_M, 7'd64);
        send_item(MODE_END);
    endtask

    task automatic test_filter();
        write_use_all(1'b0);
        send_item(MODE_CLEAR);
        for (int i = 0; i < FDEPTH + 1; i++) send_item(MODE_ADD, 31'(50 + (i % 40) * 2));
        send_item(MODE_BEGIN, 31'd48, 16'h8000);
        for (int i = 0; i < 6; i++) send_item(MODE_BASE, 0, 0, 4'd2, 8'd30);
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_M, 7'd6);
        send_item(MODE_CIGAR, 0, 0, 0, 0, CIG_D, 7'd4);
        send_item(MODE_END);
        send_item(MODE_CLEAR);
        send_item(MODE_ADD, 31'h7FFF_FFFF);
        send_item(MODE_ADD, 31'd3);
        write_use_all(1'b1);
    endtask

    // Well-formed reads with random content, plus noise items
    task automatic test_random_reads(input int limit);
        int start;
        logic [3:0] op;
        start = n_items;
        while (n_items - start < limit) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(3'($urandom_range(0, 7)), 31'($urandom), 16'($urandom),
                          4'($urandom), 8'($urandom), 4'($urandom), 7'($urandom));
                continue;
            end
            if ($urandom_range(0, 3) == 0)
                send_item(MODE_ADD, 31'($urandom_range(1, 200)));
            send_item(MODE_BEGIN, ($urandom_range(0, 9) == 0) ? 31'($urandom)
                      : 31'($urandom_range(0, 150)), 16'($urandom));
            repeat ($urandom_range(0, 8))
                send_item(MODE_BASE, 0, 0, 4'($urandom), 8'($urandom));
            repeat ($urandom_range(1, 4)) begin
                op = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                     : (($urandom_range(0, 1) == 0) ? CIG_M : CIG_D);
                send_item(MODE_CIGAR, 0, 0, 0, 0, op,
                          ($urandom_range(0, 15) == 0) ? 7'($urandom)
                          : 7'($urandom_range(0, 8)));
            end
            send_item(MODE_END);
            if ($urandom_range(0, 20) == 0) drain();   // sender waits for every result
        end
    endtask

    initial begin
        in_ch.valid = 0; in_ch.mode = 0; in_ch.position = 0; in_ch.read_flag = 0;
        in_ch.base_code = 0; in_ch.quality = 0; in_ch.cigar_op = 0; in_ch.op_length = 0;
        cfg_ch.valid = 0; cfg_ch.data = 0;
        out_ch.ready = 1;
        use_all = 1; cursor = 0; rd_ptr = 0; wr_ptr = 0; stopped = 0;
        run_len = 0; best_run = 0; flag_held = 0;
        for (int i = 0; i < FDEPTH; i++) filt_ok[i] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_use_all(1'b1);
        test_directed_extremes();
        test_stop_ops();
        drain();
        test_queue_full();
        test_filter();
        stall_en = 1'b0;
        test_random_reads(12);
        stall_en = 1'b1;
        write_use_all(1'b0);
        test_random_reads(12);
        drain();
        $display("covered %0d items and %0d results over reads, filters and stop ops",
                 n_items, n_results);
        if (errors == 0 && placed_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
